/* hw/rtl/jfps_pkg.sv */
// jfps_pkg: shared constants and types of the five-point jacobi sweep
// used by every module under hw/rtl; depends on nothing
package jfps_pkg;

   localparam int COL_W      = 10;
   localparam int MAX_WIDTH  = 1 << COL_W;
   localparam int ROW_W      = 16;
   localparam int DATA_W     = 32;
   localparam int SUM_W      = DATA_W + 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int WIDTH_W    = COL_W + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = CSR_IDX_W'(1);

   localparam logic [WIDTH_W-1:0] MIN_WIDTH     = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_VAL = WIDTH_W'(MAX_WIDTH);
   localparam logic [ROW_W-1:0]   MIN_HEIGHT    = ROW_W'(2);
   localparam logic [ROW_W-1:0]   RESET_HEIGHT  = ROW_W'(1024);

   typedef struct packed {
      logic [COL_W-1:0]         col;
      logic [ROW_W-1:0]         row;
      logic signed [DATA_W-1:0] sample;
      logic                     prev_bank;
      logic                     emit_cell;
      logic                     pass_thru;
      logic                     emit_self;
      logic                     last_col;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [COL_W-1:0]         col;
      logic [ROW_W-1:0]         row;
      logic                     frame_end;
   } rsp_item_type;

endpackage

/* hw/rtl/jfps_line_mem.sv */
// jfps_line_mem: one bank of the line store, one write port and two read ports
// synchronous read into output registers, read data held when not enabled; uses jfps_pkg
module jfps_line_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [jfps_pkg::COL_W-1:0]   wr_addr,
   input  logic [jfps_pkg::DATA_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [jfps_pkg::COL_W-1:0]   rd_addr_a,
   input  logic [jfps_pkg::COL_W-1:0]   rd_addr_b,
   output logic [jfps_pkg::DATA_W-1:0]  rd_data_a,
   output logic [jfps_pkg::DATA_W-1:0]  rd_data_b
);
   import jfps_pkg::*;

   logic [DATA_W-1:0] line_ff [MAX_WIDTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= line_ff[rd_addr_a];
         rd_b_ff <= line_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hw/rtl/jfps_stencil.sv */
// jfps_stencil: second stage, forms the cell result and the last-row echo
// takes line store read data and the registered cell control; uses jfps_pkg
module jfps_stencil (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  jfps_pkg::cell_ctl_type       ctl_in,
   input  logic                         advance,
   input  logic [jfps_pkg::DATA_W-1:0]  bank0_mid,
   input  logic [jfps_pkg::DATA_W-1:0]  bank0_right,
   input  logic [jfps_pkg::DATA_W-1:0]  bank1_mid,
   input  logic [jfps_pkg::DATA_W-1:0]  bank1_right,
   output logic                         busy,
   output logic [1:0]                   push_n,
   output jfps_pkg::rsp_item_type       item0,
   output jfps_pkg::rsp_item_type       item1
);
   import jfps_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   cell_ctl_type        ctl_ff;
   logic [DATA_W-1:0]   left_ff;
   logic [DATA_W-1:0]   center;
   logic [DATA_W-1:0]   right;
   logic [DATA_W-1:0]   above;
   logic signed [SUM_W-1:0] sum;
   logic [DATA_W-1:0]   cell_value;
   rsp_item_type        cell_item;
   rsp_item_type        self_item;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff <= ctl_in;
      end
      if (advance) begin
         left_ff <= center;
      end
   end

   assign center = ctl_ff.prev_bank ? bank1_mid   : bank0_mid;
   assign right  = ctl_ff.prev_bank ? bank1_right : bank0_right;
   assign above  = ctl_ff.prev_bank ? bank0_mid   : bank1_mid;

   // exact 34-bit sum, arithmetic shift by two floors the quarter
   assign sum = SUM_W'($signed(above)) + SUM_W'($signed(left_ff))
              + SUM_W'($signed(right)) + SUM_W'($signed(ctl_ff.sample));
   assign cell_value = ctl_ff.pass_thru ? center : sum[SUM_W-1:2];

   always_comb begin
      cell_item.value     = cell_value;
      cell_item.col       = ctl_ff.col;
      cell_item.row       = ctl_ff.row - ROW_W'(1);
      cell_item.frame_end = 1'b0;
      self_item.value     = ctl_ff.sample;
      self_item.col       = ctl_ff.col;
      self_item.row       = ctl_ff.row;
      self_item.frame_end = ctl_ff.last_col;
   end

   assign item0  = ctl_ff.emit_cell ? cell_item : self_item;
   assign item1  = self_item;
   assign push_n = advance ? (2'(ctl_ff.emit_cell) + 2'(ctl_ff.emit_self)) : 2'd0;
   assign busy   = valid_ff;

endmodule

/* hw/rtl/jfps_rsp_fifo.sv */
// jfps_rsp_fifo: small result queue that takes up to two results a cycle
// drives the rsp_ channel; uses jfps_pkg
module jfps_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_n,
   input  jfps_pkg::rsp_item_type  item0,
   input  jfps_pkg::rsp_item_type  item1,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output jfps_pkg::rsp_item_type  out_item
);
   import jfps_pkg::*;

   rsp_item_type           entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]  wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]  rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff;
   logic [FIFO_CNT_W-1:0]  count_in;
   logic                   pop;
   logic [FIFO_PTR_W-1:0]  wr_next;

   assign pop     = out_valid && out_ready;
   assign wr_next = wr_ptr_ff + FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= item0;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_next] <= item1;
      end
   end

   assign room      = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];

endmodule

/* hw/rtl/jacobi_five_point_sweep.sv */
// One Jacobi sweep of a five-point stencil over a grid streamed in raster order, one signed
// Q8.24 sample per transfer. A new sample is taken every cycle while the output queue has
// room; each sample's results are pushed into the queue from the registered stencil stage.
// From row 1 on, the sample at (x,y) yields cell (x,y-1); samples of the last row also yield
// themselves, so on that row the output channel, at one result per cycle, sets the pace of
// the samples. Two line store banks of 1024 x 32 bits, each with one write and two read ports,
// hold the last two rows and need no clearing after reset. A csr_ write to either register
// restarts the frame. Depends on jfps_pkg, jfps_line_mem, jfps_stencil and jfps_rsp_fifo.
module jacobi_five_point_sweep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [jfps_pkg::DATA_W-1:0] req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [jfps_pkg::DATA_W-1:0] rsp_new_value,
   output logic [jfps_pkg::COL_W-1:0]        rsp_out_col,
   output logic [jfps_pkg::ROW_W-1:0]        rsp_out_row,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [jfps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jfps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import jfps_pkg::*;

   logic [COL_W-1:0]   last_col_ff;
   logic [COL_W-1:0]   last_col_in;
   logic [ROW_W-1:0]   last_row_ff;
   logic [ROW_W-1:0]   last_row_in;
   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic               bank_ff;
   logic               bank_in;
   logic               req_xfer;
   logic               csr_xfer;
   logic               csr_hit;
   logic [WIDTH_W-1:0] wr_width;
   logic [ROW_W-1:0]   wr_height;
   cell_ctl_type       ctl;
   logic               stage_busy;
   logic               advance;
   logic               room;
   logic [1:0]         push_n;
   rsp_item_type       item0;
   rsp_item_type       item1;
   rsp_item_type       out_item;
   logic [COL_W-1:0]   col_right;
   logic [DATA_W-1:0]  bank0_mid;
   logic [DATA_W-1:0]  bank0_right;
   logic [DATA_W-1:0]  bank1_mid;
   logic [DATA_W-1:0]  bank1_right;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign csr_hit   = csr_xfer && (csr_index == REG_GRID_WIDTH || csr_index == REG_GRID_HEIGHT);
   assign advance   = stage_busy && room;
   assign req_ready = !stage_busy || advance;
   assign req_xfer  = req_valid && req_ready;
   assign wr_width  = csr_wdata[WIDTH_W-1:0];
   assign wr_height = csr_wdata[ROW_W-1:0];

   // effective sizes kept as last index, clamped on write
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_xfer && csr_index == REG_GRID_WIDTH) begin
         if (wr_width < MIN_WIDTH) begin
            last_col_in = COL_W'(MIN_WIDTH - WIDTH_W'(1));
         end else if (wr_width > MAX_WIDTH_VAL) begin
            last_col_in = COL_W'(MAX_WIDTH_VAL - WIDTH_W'(1));
         end else begin
            last_col_in = COL_W'(wr_width - WIDTH_W'(1));
         end
      end
      if (csr_xfer && csr_index == REG_GRID_HEIGHT) begin
         if (wr_height < MIN_HEIGHT) begin
            last_row_in = MIN_HEIGHT - ROW_W'(1);
         end else begin
            last_row_in = wr_height - ROW_W'(1);
         end
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bank_in = bank_ff;
      if (csr_hit) begin
         col_in  = '0;
         row_in  = '0;
         bank_in = 1'b0;
      end else if (req_xfer) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            if (row_ff == last_row_ff) begin
               row_in  = '0;
               bank_in = 1'b0;
            end else begin
               row_in  = row_ff + ROW_W'(1);
               bank_in = !bank_ff;
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= COL_W'(MAX_WIDTH - 1);
         last_row_ff <= RESET_HEIGHT - ROW_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         bank_ff     <= 1'b0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         bank_ff     <= bank_in;
      end
   end

   always_comb begin
      ctl.col       = col_ff;
      ctl.row       = row_ff;
      ctl.sample    = req_sample;
      ctl.prev_bank = bank_ff;
      ctl.emit_cell = row_ff != '0;
      ctl.pass_thru = (row_ff == ROW_W'(1)) || (col_ff == '0) || (col_ff == last_col_ff);
      ctl.emit_self = row_ff == last_row_ff;
      ctl.last_col  = col_ff == last_col_ff;
   end

   assign col_right = col_ff + COL_W'(1);

   // the sample replaces the row two back at its column
   jfps_line_mem u_bank0 (
      .clock     (clock),
      .wr_en     (req_xfer && bank_ff),
      .wr_addr   (col_ff),
      .wr_data   (req_sample),
      .rd_en     (req_xfer),
      .rd_addr_a (col_ff),
      .rd_addr_b (col_right),
      .rd_data_a (bank0_mid),
      .rd_data_b (bank0_right)
   );

   jfps_line_mem u_bank1 (
      .clock     (clock),
      .wr_en     (req_xfer && !bank_ff),
      .wr_addr   (col_ff),
      .wr_data   (req_sample),
      .rd_en     (req_xfer),
      .rd_addr_a (col_ff),
      .rd_addr_b (col_right),
      .rd_data_a (bank1_mid),
      .rd_data_b (bank1_right)
   );

   jfps_stencil u_stencil (
      .clock       (clock),
      .reset       (reset),
      .load        (req_xfer),
      .ctl_in      (ctl),
      .advance     (advance),
      .bank0_mid   (bank0_mid),
      .bank0_right (bank0_right),
      .bank1_mid   (bank1_mid),
      .bank1_right (bank1_right),
      .busy        (stage_busy),
      .push_n      (push_n),
      .item0       (item0),
      .item1       (item1)
   );

   jfps_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .item0     (item0),
      .item1     (item1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (out_item)
   );

   assign rsp_new_value = out_item.value;
   assign rsp_out_col   = out_item.col;
   assign rsp_out_row   = out_item.row;
   assign rsp_frame_end = out_item.frame_end;

endmodule
